[hw/rtl/ppp_pkg.sv]
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants of the perspective point projection unit
// Widths, register indexes, reset values and the item types that pass between
// the front, the queue and the back of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned SIZE_W     = 14;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned NUM_MAT    = 6;
  localparam int unsigned PROD_W     = POS_W + COEF_W;
  localparam int unsigned PROD_SHIFT = 8;
  localparam int unsigned ACC_W      = 58;
  localparam int unsigned MAG_W      = ACC_W + 1;
  localparam int unsigned DIV_W      = ACC_W - 1;
  localparam int unsigned SCALE_SH   = 7;
  localparam int unsigned KK_W       = SIZE_W + SCALE_SH;
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned P0_W       = QUO_W + KK_W;
  localparam int unsigned P1_W       = MAG_W - QUO_W + KK_W;
  localparam int unsigned NUM_W      = MAG_W + KK_W + 2;

  localparam logic signed [ACC_W-1:0] W_THRESHOLD = ACC_W'(16778);

  localparam logic [CFG_W-1:0]  RST_ROW0_01 = 64'd16777216;
  localparam logic [CFG_W-1:0]  RST_ROW0_23 = 64'd0;
  localparam logic [CFG_W-1:0]  RST_ROW1_01 = 64'd72057594037927936;
  localparam logic [CFG_W-1:0]  RST_ROW1_23 = 64'd0;
  localparam logic [CFG_W-1:0]  RST_ROW3_01 = 64'd0;
  localparam logic [CFG_W-1:0]  RST_ROW3_23 = 64'd72057594037927936;
  localparam logic [SIZE_W-1:0] RST_WIDTH   = 14'd1920;
  localparam logic [SIZE_W-1:0] RST_HEIGHT  = 14'd1080;

  localparam logic [QUO_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_01  = 3'd0,
    REG_ROW0_23  = 3'd1,
    REG_ROW1_01  = 3'd2,
    REG_ROW1_23  = 3'd3,
    REG_ROW3_01  = 3'd4,
    REG_ROW3_23  = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [NUM_MAT-1:0][CFG_W-1:0] mat;
    logic [SIZE_W-1:0]             width;
    logic [SIZE_W-1:0]             height;
  } cfg_t;

  typedef struct packed {
    logic                  vis;
    logic [DIV_W-1:0]      w;
    logic [1:0]            neg;
    logic [1:0][MAG_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic             vis;
    logic [DIV_W-1:0] w;
    logic [1:0]       neg;
  } meta_t;

  function automatic logic [COEF_W-1:0] coef(cfg_t c, int unsigned row, int unsigned col);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(2 * row) + IDX_W'(col >> 1);
    return c.mat[idx][(col & 1) * COEF_W +: COEF_W];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ppp_front.sv]
// ----------------------------------------------------------------------------
// ppp_front: row products, sums and visibility classification
// Three pipeline stages compute clip x, clip y and w, test w against the
// near threshold and form the signed dividends for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppp_front import ppp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output item_t                   item_o
);

  logic                     en;
  logic                     v1_q, v2_q, v3_q;
  logic signed [POS_W-1:0]  pos [3];
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [ACC_W-1:0]  acc_d [3];
  logic signed [ACC_W-1:0]  acc_q [3];
  logic signed [MAG_W-1:0]  dvd [2];
  item_t                    item_d, item_q;

  assign en = !v3_q || out_ready_i;

  always_comb begin
    pos[0] = pos_x_i;
    pos[1] = pos_y_i;
    pos[2] = pos_z_i;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(coef(cfg_i, r, c)) * pos[c];
      end
      acc_d[r] = ACC_W'(prod_q[r][0] >>> PROD_SHIFT) + ACC_W'(prod_q[r][1] >>> PROD_SHIFT)
               + ACC_W'(prod_q[r][2] >>> PROD_SHIFT) + ACC_W'($signed(coef(cfg_i, r, 3)));
    end
  end

  always_comb begin
    dvd[0] = MAG_W'(acc_q[2]) + MAG_W'(acc_q[0]);
    dvd[1] = MAG_W'(acc_q[2]) - MAG_W'(acc_q[1]);
    item_d.vis = acc_q[2] >= W_THRESHOLD;
    item_d.w   = acc_q[2][DIV_W-1:0];
    for (int k = 0; k < 2; k++) begin
      item_d.neg[k] = dvd[k][MAG_W-1];
      item_d.mag[k] = dvd[k][MAG_W-1] ? (~dvd[k] + 1'b1) : dvd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      item_q <= item_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = v3_q;
  assign item_o      = item_q;

endmodule

`default_nettype wire

[hw/rtl/ppp_queue.sv]
// ----------------------------------------------------------------------------
// ppp_queue: short first-in first-out queue between front and back
// Register-based storage with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppp_queue import ppp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == FULL;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LAST) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == LAST) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ppp_back.sv]
// ----------------------------------------------------------------------------
// ppp_back: screen scaling, pipelined division and saturation
// Scales both dividends by the screen size, divides by w one quotient bit per
// stage and saturates the results into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppp_back import ppp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] width_i,
  input  logic [SIZE_W-1:0] height_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              visible_o,
  output logic [QUO_W-1:0]  screen_x_o,
  output logic [QUO_W-1:0]  screen_y_o
);

  logic             en;
  logic             v1_q, v2_q, ov_q;
  logic [QUO_W:0]   dv_q;
  logic [KK_W-1:0]  kk [2];
  logic [P0_W-1:0]  p0_q [2];
  logic [P1_W-1:0]  p1_q [2];
  logic [NUM_W-1:0] num_q [2];
  meta_t            meta1_q, meta2_q;
  meta_t            meta_q [QUO_W+1];
  logic [DIV_W-1:0] rem_q  [QUO_W+1][2];
  logic [QUO_W-1:0] lo_q   [QUO_W+1][2];
  logic [QUO_W-1:0] quo_q  [QUO_W+1][2];
  logic             big_q  [QUO_W+1][2];
  logic [DIV_W-1:0] rem_n  [QUO_W][2];
  logic             ge_n   [QUO_W][2];
  logic [QUO_W-1:0] res_d  [2];
  logic [QUO_W-1:0] res_q  [2];
  logic             vis_q;

  assign en = !ov_q || out_ready_i;
  assign kk[0] = {width_i, SCALE_SH'(0)};
  assign kk[1] = {height_i, SCALE_SH'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      dv_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      dv_q <= {dv_q[QUO_W-1:0], v2_q};
      ov_q <= dv_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta1_q    <= '{vis: item_i.vis, w: item_i.w, neg: item_i.neg};
      meta2_q    <= meta1_q;
      meta_q[0]  <= meta2_q;
      for (int k = 0; k < 2; k++) begin
        p0_q[k] <= P0_W'(item_i.mag[k][QUO_W-1:0]) * P0_W'(kk[k]);
        p1_q[k] <= P1_W'(item_i.mag[k][MAG_W-1:QUO_W]) * P1_W'(kk[k]);
        num_q[k] <= NUM_W'(p0_q[k]) + (NUM_W'(p1_q[k]) << QUO_W);
        rem_q[0][k] <= DIV_W'(num_q[k][NUM_W-1:QUO_W]);
        lo_q[0][k]  <= num_q[k][QUO_W-1:0];
        quo_q[0][k] <= '0;
        big_q[0][k] <= DIV_W'(num_q[k][NUM_W-1:QUO_W]) >= meta2_q.w;
      end
    end
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    always_comb begin
      logic [DIV_W:0] t;
      for (int k = 0; k < 2; k++) begin
        t = {rem_q[s][k], lo_q[s][k][QUO_W-1]};
        ge_n[s][k]  = t >= {1'b0, meta_q[s].w};
        rem_n[s][k] = ge_n[s][k] ? DIV_W'(t - {1'b0, meta_q[s].w}) : t[DIV_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        meta_q[s+1] <= meta_q[s];
        for (int k = 0; k < 2; k++) begin
          rem_q[s+1][k] <= rem_n[s][k];
          lo_q[s+1][k]  <= {lo_q[s][k][QUO_W-2:0], 1'b0};
          quo_q[s+1][k] <= {quo_q[s][k][QUO_W-2:0], ge_n[s][k]};
          big_q[s+1][k] <= big_q[s][k];
        end
      end
    end
  end

  always_comb begin
    logic [QUO_W:0] qq;
    for (int k = 0; k < 2; k++) begin
      qq = {1'b0, quo_q[QUO_W][k]} + (QUO_W+1)'(|rem_q[QUO_W][k]);
      if (!meta_q[QUO_W].vis) begin
        res_d[k] = '0;
      end else if (!meta_q[QUO_W].neg[k]) begin
        res_d[k] = (big_q[QUO_W][k] || quo_q[QUO_W][k][QUO_W-1]) ? SAT_MAX : quo_q[QUO_W][k];
      end else if (big_q[QUO_W][k] || qq > {1'b0, SAT_MIN}) begin
        res_d[k] = SAT_MIN;
      end else begin
        res_d[k] = QUO_W'(~qq + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      vis_q <= meta_q[QUO_W].vis;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = ov_q;
  assign visible_o   = vis_q;
  assign screen_x_o  = res_q[0];
  assign screen_y_o  = res_q[1];

endmodule

`default_nettype wire

[hw/rtl/perspective_point_projection_unit.sv]
// ----------------------------------------------------------------------------
// perspective_point_projection_unit: world point to screen pixel projection
// Top level with configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// The unit accepts one world point per clock cycle while it is not full and
// returns one result per point in order, through three stages in the front for
// the row products and sums, the queue, and in the back two scaling stages, a
// compare stage, thirty-two quotient stages of the divider and the output
// register. The divider stages set the latency; throughput stays at one point
// per cycle as long as results are popped. The user must write matrix and screen
// size only while the unit holds no points; the unit does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module perspective_point_projection_unit import ppp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    visible_o,
  output logic signed [QUO_W-1:0] screen_x_o,
  output logic signed [QUO_W-1:0] screen_y_o,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  cfg_t  cfg_q;
  logic  front_ready, front_valid, q_full, q_empty, back_ready, back_valid;
  item_t front_item, q_item;
  logic [QUO_W-1:0] sx, sy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mat[0] <= RST_ROW0_01;
      cfg_q.mat[1] <= RST_ROW0_23;
      cfg_q.mat[2] <= RST_ROW1_01;
      cfg_q.mat[3] <= RST_ROW1_23;
      cfg_q.mat[4] <= RST_ROW3_01;
      cfg_q.mat[5] <= RST_ROW3_23;
      cfg_q.width  <= RST_WIDTH;
      cfg_q.height <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ROW0_01: cfg_q.mat[0] <= cfg_data_i;
        REG_ROW0_23: cfg_q.mat[1] <= cfg_data_i;
        REG_ROW1_01: cfg_q.mat[2] <= cfg_data_i;
        REG_ROW1_23: cfg_q.mat[3] <= cfg_data_i;
        REG_ROW3_01: cfg_q.mat[4] <= cfg_data_i;
        REG_ROW3_23: cfg_q.mat[5] <= cfg_data_i;
        REG_WIDTH:   cfg_q.width  <= cfg_data_i[SIZE_W-1:0];
        REG_HEIGHT:  cfg_q.height <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .out_valid_o (front_valid),
    .out_ready_i (!q_full),
    .item_o      (front_item)
  );

  ppp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (q_full),
    .pop_i   (back_ready),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  ppp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (cfg_q.width),
    .height_i    (cfg_q.height),
    .in_valid_i  (!q_empty),
    .in_ready_o  (back_ready),
    .item_i      (q_item),
    .out_valid_o (back_valid),
    .out_ready_i (pop),
    .visible_o   (visible_o),
    .screen_x_o  (sx),
    .screen_y_o  (sy)
  );

  assign full       = !front_ready;
  assign empty      = !back_valid;
  assign screen_x_o = $signed(sx);
  assign screen_y_o = $signed(sy);

endmodule

`default_nettype wire

[hw/rtl/ppp_checker.sv]
// ----------------------------------------------------------------------------
// ppp_checker: port-level checks of the projection unit
// Watches the queue-style ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppp_checker import ppp_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic                    visible_o,
  input logic signed [QUO_W-1:0] screen_x_o,
  input logic signed [QUO_W-1:0] screen_y_o
);

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !visible_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("hidden point with nonzero coordinates");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("unit not idle during reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(visible_o) && $stable(screen_x_o)
                          && $stable(screen_y_o)))
    else $error("waiting result changed before pop");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !$past(empty) && rst_ni && $past(rst_ni)) |-> $past(pop))
    else $error("result vanished without pop");

endmodule

bind perspective_point_projection_unit ppp_checker u_ppp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .visible_o  (visible_o),
  .screen_x_o (screen_x_o),
  .screen_y_o (screen_y_o)
);

`default_nettype wire

[verif/tb_perspective_point_projection_unit.sv]
// ----------------------------------------------------------------------------
// tb_perspective_point_projection_unit: self-checking testbench of the projection unit
// Drives world points through the queue-style input with random gaps. It pops
// the results with random stalls and with one long hold-off that fills the
// unit. It checks every result against a fixed-point projection computed here,
// and it changes the matrix and screen size between phases while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_perspective_point_projection_unit;
  import ppp_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic        vis;
    logic [31:0] sx;
    logic [31:0] sy;
  } pixel_t;

  class projection_scoreboard;
    logic [CFG_W-1:0]  mat [NUM_MAT];
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    pixel_t            pending [$];
    int                errors;

    function new();
      mat[0] = RST_ROW0_01;
      mat[1] = RST_ROW0_23;
      mat[2] = RST_ROW1_01;
      mat[3] = RST_ROW1_23;
      mat[4] = RST_ROW3_01;
      mat[5] = RST_ROW3_23;
      width  = RST_WIDTH;
      height = RST_HEIGHT;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      if (idx == REG_WIDTH) width = data[SIZE_W-1:0];
      else if (idx == REG_HEIGHT) height = data[SIZE_W-1:0];
      else mat[idx] = data;
    endfunction

    function longint row_sum(logic [CFG_W-1:0] r01, logic [CFG_W-1:0] r23,
                             longint px, longint py, longint pz);
      longint acc;
      acc = (longint'($signed(r01[31:0])) * px) >>> 8;
      acc += (longint'($signed(r01[63:32])) * py) >>> 8;
      acc += (longint'($signed(r23[31:0])) * pz) >>> 8;
      acc += longint'($signed(r23[63:32]));
      return acc;
    endfunction

    function logic [31:0] to_pixel(logic [SIZE_W-1:0] k, longint a, longint d);
      logic signed [127:0] kk, num, q, r, dd;
      kk  = k;
      dd  = d;
      num = kk * 128 * a;
      q   = num / dd;
      r   = num % dd;
      if (r != 0 && num < 0) q = q - 1;
      if (q > 128'sd2147483647) return SAT_MAX;
      if (q < -128'sd2147483648) return SAT_MIN;
      return q[31:0];
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint px, py, pz, w, cx, cy;
      pixel_t e;
      px = longint'($signed(x));
      py = longint'($signed(y));
      pz = longint'($signed(z));
      w  = row_sum(mat[4], mat[5], px, py, pz);
      e  = '{vis: 1'b0, sx: '0, sy: '0};
      if (w >= 16778) begin
        cx    = row_sum(mat[0], mat[1], px, py, pz);
        cy    = row_sum(mat[2], mat[3], px, py, pz);
        e.vis = 1'b1;
        e.sx  = to_pixel(width, w + cx, w);
        e.sy  = to_pixel(height, w - cy, w);
      end
      pending.push_back(e);
    endfunction

    function void check_pixel(logic vis, logic [31:0] sx, logic [31:0] sy);
      pixel_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result vis=%0b x=%h y=%h", $time, vis, sx, sy);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vis !== e.vis) begin
        $display("%0t: visible expected %0b actual %0b", $time, e.vis, vis);
        errors++;
      end
      if (sx !== e.sx) begin
        $display("%0t: screen_x expected %h actual %h", $time, e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $display("%0t: screen_y expected %h actual %h", $time, e.sy, sy);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push = 1'b0;
  logic              full;
  logic [POS_W-1:0]  pos_x = '0, pos_y = '0, pos_z = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              visible;
  logic [QUO_W-1:0]  screen_x, screen_y;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  projection_scoreboard sb = new();
  bit idle_on = 1'b1;
  int hold_left = 0;
  int cycles = 0;

  perspective_point_projection_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .empty       (empty),
    .pop         (pop),
    .visible_o   (visible),
    .screen_x_o  (screen_x),
    .screen_y_o  (screen_y),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, plus the long hold-off when one is requested.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) sb.check_pixel(visible, screen_x, screen_y);
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    push  <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    do @(posedge clk_i); while (full);
    sb.note_point(x, y, z);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] near_coef(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic random_matrix();
    write_reg(REG_ROW0_01, {near_coef(1 << 26), near_coef(1 << 26)});
    write_reg(REG_ROW0_23, {near_coef(1 << 28), near_coef(1 << 26)});
    write_reg(REG_ROW1_01, {near_coef(1 << 26), near_coef(1 << 26)});
    write_reg(REG_ROW1_23, {near_coef(1 << 28), near_coef(1 << 26)});
    write_reg(REG_ROW3_01, {near_coef(1 << 20), near_coef(1 << 20)});
    write_reg(REG_ROW3_23, {32'($urandom_range(1, 1 << 27)), near_coef(1 << 22)});
  endtask

  task automatic random_points(int count);
    logic [31:0] x, y, z;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        x = $urandom; y = $urandom; z = $urandom;
      end else begin
        x = near_coef(1 << 16); y = near_coef(1 << 16);
        z = 32'($urandom_range(0, 1 << 16));
      end
      send_point(x, y, z);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'd256, 32'd256, 32'd0);
    send_point(-32'sd256, -32'sd256, 32'd5);
    send_point(32'h0000_00FF, 32'hFFFF_FF00, 32'd0);
    random_points(100);
    wait_idle();

    write_reg(REG_ROW3_23, {32'd16777, 32'd0});
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    random_points(40);
    wait_idle();

    write_reg(REG_ROW3_23, {32'd16778, 32'd0});
    write_reg(REG_WIDTH, 64'hFFFF);
    write_reg(REG_HEIGHT, {$urandom, $urandom} | 64'h3FFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    random_points(60);
    wait_idle();

    write_reg(REG_ROW3_23, {32'd0, 32'h0100_0000});
    write_reg(REG_WIDTH, 64'd8192);
    write_reg(REG_HEIGHT, 64'd8192);
    send_point(32'd100, 32'd100, 32'd0);
    send_point(32'd100, 32'd100, 32'd1);
    send_point(32'd100, 32'd100, -32'sd1);
    send_point(32'd100, 32'd100, 32'h7FFF_FFFF);
    send_point(32'd100, 32'd100, 32'h8000_0000);
    random_points(200);
    wait_idle();

    for (int i = 0; i < NUM_MAT; i++) write_reg(reg_idx_e'(i), {$urandom, $urandom});
    write_reg(REG_ROW3_23, 64'hFFFF_FFFF_FFFF_FFFF);
    random_points(150);
    wait_idle();

    random_matrix();
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd1);
    random_points(100);
    wait_idle();

    write_reg(REG_WIDTH, 64'd1);
    write_reg(REG_HEIGHT, 64'd0);
    random_points(100);
    wait_idle();

    random_matrix();
    write_reg(REG_WIDTH, 64'($urandom_range(1, 8192)));
    write_reg(REG_HEIGHT, 64'($urandom_range(1, 8192)));
    hold_left = 300;
    random_points(250);
    wait_idle();

    random_matrix();
    write_reg(REG_WIDTH, 64'd1920);
    write_reg(REG_HEIGHT, 64'd1080);
    idle_on = 1'b0;
    random_points(200);
    wait_idle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ppp_pkg.sv
hw/rtl/ppp_front.sv
hw/rtl/ppp_queue.sv
hw/rtl/ppp_back.sv
hw/rtl/perspective_point_projection_unit.sv
hw/rtl/ppp_checker.sv
verif/tb_perspective_point_projection_unit.sv
